// ===== rtl/core/vtfc_pkg.sv =====
`default_nettype none
package vtfc_pkg;

  localparam int COORD_WIDTH    = 16;
  localparam int COEF_FRAC_BITS = 8;
  localparam int COEF_WIDTH     = 16;
  localparam int ROW_WIDTH      = 64;
  localparam int ZROW_WIDTH     = 48;
  localparam int COLOR_WIDTH    = 32;
  localparam int CFG_IDX_WIDTH  = 2;

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_X_ROW = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_Y_ROW = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_Z_ROW = 2'd2;

  localparam logic [ROW_WIDTH-1:0]  X_ROW_RESET = 64'd256;
  localparam logic [ROW_WIDTH-1:0]  Y_ROW_RESET = 64'd16777216;
  localparam logic [ZROW_WIDTH-1:0] Z_ROW_RESET = 48'd1099511627776;

  typedef enum logic [2:0] {
    FACE_POS_X = 3'd0,
    FACE_NEG_X = 3'd1,
    FACE_POS_Y = 3'd2,
    FACE_NEG_Y = 3'd3,
    FACE_POS_Z = 3'd4,
    FACE_NEG_Z = 3'd5,
    FACE_NONE  = 3'd6
  } face_dir_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] v0_x;
    logic signed [COORD_WIDTH-1:0] v0_y;
    logic signed [COORD_WIDTH-1:0] v0_z;
    logic signed [COORD_WIDTH-1:0] v1_x;
    logic signed [COORD_WIDTH-1:0] v1_y;
    logic signed [COORD_WIDTH-1:0] v1_z;
    logic signed [COORD_WIDTH-1:0] v2_x;
    logic signed [COORD_WIDTH-1:0] v2_y;
    logic signed [COORD_WIDTH-1:0] v2_z;
    logic [2:0]                    face_dir;
    logic [COLOR_WIDTH-1:0]        tri_color;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] p0_x;
    logic signed [COORD_WIDTH-1:0] p0_y;
    logic signed [COORD_WIDTH-1:0] p1_x;
    logic signed [COORD_WIDTH-1:0] p1_y;
    logic signed [COORD_WIDTH-1:0] p2_x;
    logic signed [COORD_WIDTH-1:0] p2_y;
    logic [COLOR_WIDTH-1:0]        out_color;
  } out_item_t;

endpackage
`default_nettype wire

// ===== rtl/core/vtfc_proj.sv =====
`default_nettype none
// One affine row: three products, sum with translation and rounding, floor shift, saturate.
module vtfc_proj #(
  parameter int FRAC_BITS = vtfc_pkg::COEF_FRAC_BITS
) (
  input  wire logic                                  clk,
  input  wire logic [vtfc_pkg::ROW_WIDTH-1:0]        row,
  input  wire logic signed [vtfc_pkg::COORD_WIDTH-1:0] x,
  input  wire logic signed [vtfc_pkg::COORD_WIDTH-1:0] y,
  input  wire logic signed [vtfc_pkg::COORD_WIDTH-1:0] z,
  output logic signed [vtfc_pkg::COORD_WIDTH-1:0]    res
);

  localparam int CW = vtfc_pkg::COORD_WIDTH;
  localparam int KW = vtfc_pkg::COEF_WIDTH;
  localparam int PW = KW + CW;
  localparam int TW = KW + FRAC_BITS;
  localparam int SW = ((PW > TW) ? PW : TW) + 3;
  localparam logic signed [SW-1:0] HALF = SW'(1) << (FRAC_BITS - 1);

  logic signed [PW-1:0] prod_r [3];
  logic signed [SW-1:0] trans_r;
  logic signed [SW-1:0] sum_r;
  logic signed [SW-1:0] sum_nxt;
  logic signed [SW-1:0] quot;
  logic signed [CW-1:0] res_r;
  logic signed [CW-1:0] res_nxt;
  logic signed [KW-1:0] cx, cy, cz, tx;

  assign cx = row[KW-1:0];
  assign cy = row[2*KW-1:KW];
  assign cz = row[3*KW-1:2*KW];
  assign tx = row[4*KW-1:3*KW];

  always_comb begin
    sum_nxt = SW'(prod_r[0]) + SW'(prod_r[1]) + SW'(prod_r[2]) + trans_r + HALF;
  end

  // floor divide, then clamp when the dropped high bits are not all sign
  always_comb begin
    quot = sum_r >>> FRAC_BITS;
    if (quot[SW-1:CW-1] == '0 || quot[SW-1:CW-1] == '1) begin
      res_nxt = quot[CW-1:0];
    end else if (quot[SW-1]) begin
      res_nxt = {1'b1, {(CW-1){1'b0}}};
    end else begin
      res_nxt = {1'b0, {(CW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    prod_r[0] <= PW'(cx) * PW'(x);
    prod_r[1] <= PW'(cy) * PW'(y);
    prod_r[2] <= PW'(cz) * PW'(z);
    trans_r   <= SW'(tx) <<< FRAC_BITS;
    sum_r     <= sum_nxt;
    res_r     <= res_nxt;
  end

  assign res = res_r;

endmodule
`default_nettype wire

// ===== rtl/core/vertex_transform_face_cull.sv =====
`default_nettype none
// Affine vertex transform with axis face culling.
//
// Input channel: a triangle item (three vertices, face direction, color) is
// taken at a rising edge with start high and busy low. busy is low except
// during reset: the pipeline takes one item every cycle with no gaps.
// Result channel: a kept triangle shows up on out_item for exactly one cycle
// with out_valid high. It passes the multiply stage, the sum stage and the
// shift/saturate stage in that order before it appears. A culled triangle
// gives nothing. Throughput is one item per clock; the three register stages
// of each of the six projection units set the latency. The receiver cannot
// stall, so no back-pressure path exists.
// Configuration: cfg_we writes cfg_wdata to register cfg_idx (0 x_row,
// 1 y_row, 2 z_row, others ignored). Write only while the pipe is empty.
// Reset (rst_n low, synchronous) restores the identity rows, clears the
// valid bits of every stage and holds busy high.
module vertex_transform_face_cull #(
  parameter int COEF_FRAC_BITS = vtfc_pkg::COEF_FRAC_BITS
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire vtfc_pkg::in_item_t                   in_item,
  output logic                                      out_valid,
  output vtfc_pkg::out_item_t                       out_item,
  input  wire logic                                 cfg_we,
  input  wire logic [vtfc_pkg::CFG_IDX_WIDTH-1:0]   cfg_idx,
  input  wire logic [vtfc_pkg::ROW_WIDTH-1:0]       cfg_wdata
);

  localparam int CW = vtfc_pkg::COORD_WIDTH;
  localparam int KW = vtfc_pkg::COEF_WIDTH;
  localparam int NSTG = 3;

  logic [vtfc_pkg::ROW_WIDTH-1:0]  x_row_r;
  logic [vtfc_pkg::ROW_WIDTH-1:0]  y_row_r;
  logic [vtfc_pkg::ZROW_WIDTH-1:0] z_row_r;

  logic in_acc;
  logic kept;
  logic signed [KW-1:0] zx, zy, zz;

  logic [NSTG-1:0] vld_r;
  logic [vtfc_pkg::COLOR_WIDTH-1:0] color_r [NSTG];

  logic signed [CW-1:0] vx [3];
  logic signed [CW-1:0] vy [3];
  logic signed [CW-1:0] vz [3];
  logic signed [CW-1:0] px [3];
  logic signed [CW-1:0] py [3];

  // nothing is taken while reset holds the stages clear
  assign busy   = !rst_n;
  assign in_acc = start && !busy;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_row_r <= vtfc_pkg::X_ROW_RESET;
      y_row_r <= vtfc_pkg::Y_ROW_RESET;
      z_row_r <= vtfc_pkg::Z_ROW_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        vtfc_pkg::CFG_X_ROW: x_row_r <= cfg_wdata;
        vtfc_pkg::CFG_Y_ROW: y_row_r <= cfg_wdata;
        vtfc_pkg::CFG_Z_ROW: z_row_r <= cfg_wdata[vtfc_pkg::ZROW_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // cull decision on the depth row signs, made at entry
  assign zx = z_row_r[KW-1:0];
  assign zy = z_row_r[2*KW-1:KW];
  assign zz = z_row_r[3*KW-1:2*KW];

  always_comb begin
    case (in_item.face_dir)
      vtfc_pkg::FACE_POS_X: kept = zx < 0;
      vtfc_pkg::FACE_NEG_X: kept = zx > 0;
      vtfc_pkg::FACE_POS_Y: kept = zy < 0;
      vtfc_pkg::FACE_NEG_Y: kept = zy > 0;
      vtfc_pkg::FACE_POS_Z: kept = zz < 0;
      vtfc_pkg::FACE_NEG_Z: kept = zz > 0;
      default:              kept = 1'b1;  // none or unknown direction
    endcase
  end

  // valid bits travel alongside the projection stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NSTG-2:0], in_acc && kept};
    end
  end

  always_ff @(posedge clk) begin
    color_r[0] <= in_item.tri_color;
    for (int i = 1; i < NSTG; i++) begin
      color_r[i] <= color_r[i-1];
    end
  end

  always_comb begin
    vx[0] = in_item.v0_x;  vy[0] = in_item.v0_y;  vz[0] = in_item.v0_z;
    vx[1] = in_item.v1_x;  vy[1] = in_item.v1_y;  vz[1] = in_item.v1_z;
    vx[2] = in_item.v2_x;  vy[2] = in_item.v2_y;  vz[2] = in_item.v2_z;
  end

  // six projection units: x and y rows for each vertex
  for (genvar v = 0; v < 3; v++) begin : g_vert
    vtfc_proj #(.FRAC_BITS(COEF_FRAC_BITS)) u_px (
      .clk (clk),
      .row (x_row_r),
      .x   (vx[v]),
      .y   (vy[v]),
      .z   (vz[v]),
      .res (px[v])
    );
    vtfc_proj #(.FRAC_BITS(COEF_FRAC_BITS)) u_py (
      .clk (clk),
      .row (y_row_r),
      .x   (vx[v]),
      .y   (vy[v]),
      .z   (vz[v]),
      .res (py[v])
    );
  end

  assign out_valid          = vld_r[NSTG-1];
  assign out_item.p0_x      = px[0];
  assign out_item.p0_y      = py[0];
  assign out_item.p1_x      = px[1];
  assign out_item.p1_y      = py[1];
  assign out_item.p2_x      = px[2];
  assign out_item.p2_y      = py[2];
  assign out_item.out_color = color_r[NSTG-1];

  // a result always traces back to an accepted item
  a_out_has_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_acc, NSTG))
    else $error("result without accepted item");

  // a culled item never yields a result
  a_cull_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !kept) |-> ##NSTG !out_valid)
    else $error("culled item produced a result");

  // color rides along with its item
  a_color_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.out_color == $past(in_item.tri_color, NSTG))
    else $error("color out of step with item");

endmodule
`default_nettype wire

// ===== tb/vertex_transform_face_cull_tb.sv =====
`default_nettype none
module vertex_transform_face_cull_tb;
  import vtfc_pkg::*;

  // Three register stages inside; leave a margin so that culled items still in
  // flight are gone before the next register write.
  localparam int DRAIN_CYCLES = 8;
  localparam int SEG_ITEMS    = 74;   // half of one random segment
  localparam int SEGS_PER_RUN = 3;    // segments per idle setting

  // Only indexes 0..2 map to registers; the last code must be ignored.
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_UNMAPPED = 2'd3;

  localparam longint COORD_MAX = longint'(2) ** (COORD_WIDTH - 1) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;

  logic                     clk       = 1'b0;
  logic                     rst_n     = 1'b0;
  logic                     start     = 1'b0;
  logic                     busy;
  in_item_t                 in_item   = '0;
  logic                     out_valid;
  out_item_t                out_item;
  logic                     cfg_we    = 1'b0;
  logic [CFG_IDX_WIDTH-1:0] cfg_idx   = CFG_X_ROW;
  logic [ROW_WIDTH-1:0]     cfg_wdata = '0;

  // Pending triangles for the driver, and projections still owed by the block.
  in_item_t  tri_pending_q[$];
  out_item_t proj_expect_q[$];

  // Register values as the block should hold them right now.
  logic [ROW_WIDTH-1:0]  x_row_q = X_ROW_RESET;
  logic [ROW_WIDTH-1:0]  y_row_q = Y_ROW_RESET;
  logic [ZROW_WIDTH-1:0] z_row_q = Z_ROW_RESET;

  logic in_taken      = 1'b0;  // item on the input was taken at the last rising edge
  int   send_idle_pct = 0;
  int   mismatches    = 0;
  int   tris_sent     = 0;
  int   tris_kept     = 0;
  int   tris_culled   = 0;
  int   results_seen  = 0;
  int   reg_writes    = 0;

  vertex_transform_face_cull u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // One output coordinate: exact dot product plus translation at coefficient
  // scale, round half up (add half, floor), then clamp to the coordinate range.
  function automatic logic signed [COORD_WIDTH-1:0] project_coord(
      input logic [ROW_WIDTH-1:0] row,
      input logic signed [COORD_WIDTH-1:0] vx,
      input logic signed [COORD_WIDTH-1:0] vy,
      input logic signed [COORD_WIDTH-1:0] vz);
    logic signed [COEF_WIDTH-1:0] cx, cy, cz, tx;
    longint acc;
    cx = row[15:0];
    cy = row[31:16];
    cz = row[47:32];
    tx = row[63:48];
    acc = longint'(cx) * longint'(vx) + longint'(cy) * longint'(vy) +
          longint'(cz) * longint'(vz) + (longint'(tx) <<< COEF_FRAC_BITS) +
          (longint'(1) <<< (COEF_FRAC_BITS - 1));
    acc = acc >>> COEF_FRAC_BITS;   // arithmetic shift floors
    if (acc > COORD_MAX) acc = COORD_MAX;
    if (acc < COORD_MIN) acc = COORD_MIN;
    return acc[COORD_WIDTH-1:0];
  endfunction

  // A face survives when the depth row turns its axis toward -z. A zero
  // coefficient culls both signs of its axis; none and the unused code 7 pass.
  function automatic bit face_visible(input logic [2:0] dir,
                                      input logic [ZROW_WIDTH-1:0] zr);
    logic signed [COEF_WIDTH-1:0] zx, zy, zz;
    zx = zr[15:0];
    zy = zr[31:16];
    zz = zr[47:32];
    case (dir)
      FACE_POS_X: return zx < 16'sd0;
      FACE_NEG_X: return zx > 16'sd0;
      FACE_POS_Y: return zy < 16'sd0;
      FACE_NEG_Y: return zy > 16'sd0;
      FACE_POS_Z: return zz < 16'sd0;
      FACE_NEG_Z: return zz > 16'sd0;
      default:    return 1'b1;
    endcase
  endfunction

  function automatic out_item_t predict_projection(input in_item_t t);
    out_item_t p;
    p.p0_x      = project_coord(x_row_q, t.v0_x, t.v0_y, t.v0_z);
    p.p0_y      = project_coord(y_row_q, t.v0_x, t.v0_y, t.v0_z);
    p.p1_x      = project_coord(x_row_q, t.v1_x, t.v1_y, t.v1_z);
    p.p1_y      = project_coord(y_row_q, t.v1_x, t.v1_y, t.v1_z);
    p.p2_x      = project_coord(x_row_q, t.v2_x, t.v2_y, t.v2_z);
    p.p2_y      = project_coord(y_row_q, t.v2_x, t.v2_y, t.v2_z);
    p.out_color = t.tri_color;
    return p;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents pending triangles, one per item, changing at falling edges.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || in_taken) begin
      if (tri_pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        start   <= 1'b1;
        in_item <= tri_pending_q.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: tracks register writes, predicts at acceptance, checks results.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
      x_row_q  <= X_ROW_RESET;
      y_row_q  <= Y_ROW_RESET;
      z_row_q  <= Z_ROW_RESET;
    end else begin
      in_taken <= start && !busy;
      if (cfg_we) begin
        case (cfg_idx)
          CFG_X_ROW: x_row_q <= cfg_wdata;
          CFG_Y_ROW: y_row_q <= cfg_wdata;
          CFG_Z_ROW: z_row_q <= cfg_wdata[ZROW_WIDTH-1:0];
          default:   ;  // unmapped index, write dropped
        endcase
      end
      if (start && !busy) begin
        tris_sent++;
        if (face_visible(in_item.face_dir, z_row_q)) begin
          proj_expect_q = {proj_expect_q, predict_projection(in_item)};
          tris_kept++;
        end else begin
          tris_culled++;
        end
      end
      if (out_valid) begin
        results_seen++;
        if (proj_expect_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result: expected none, actual %h", $time, out_item);
        end else begin
          out_item_t want;
          want = proj_expect_q.pop_front();
          check_field("p0_x", 32'(want.p0_x), 32'(out_item.p0_x));
          check_field("p0_y", 32'(want.p0_y), 32'(out_item.p0_y));
          check_field("p1_x", 32'(want.p1_x), 32'(out_item.p1_x));
          check_field("p1_y", 32'(want.p1_y), 32'(out_item.p1_y));
          check_field("p2_x", 32'(want.p2_x), 32'(out_item.p2_x));
          check_field("p2_y", 32'(want.p2_y), 32'(out_item.p2_y));
          check_field("out_color", want.out_color, out_item.out_color);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_triangle(
      input logic [15:0] ax, input logic [15:0] ay, input logic [15:0] az,
      input logic [15:0] bx, input logic [15:0] by, input logic [15:0] bz,
      input logic [15:0] qx, input logic [15:0] qy, input logic [15:0] qz,
      input logic [2:0] dir, input logic [31:0] color);
    in_item_t t;
    t.v0_x = ax; t.v0_y = ay; t.v0_z = az;
    t.v1_x = bx; t.v1_y = by; t.v1_z = bz;
    t.v2_x = qx; t.v2_y = qy; t.v2_z = qz;
    t.face_dir  = dir;
    t.tri_color = color;
    tri_pending_q = {tri_pending_q, t};
  endtask

  // Coordinates: extremes, a cluster near zero, and the full range.
  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 5))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2, 3:    return 16'($urandom_range(0, 1023) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  // Q7.8 coefficients: zero, +-1.0, extremes, small values and anything.
  function automatic logic [15:0] pick_coef();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'h7FFF;
      2:       return 16'h8000;
      3:       return 16'h0100;
      4:       return 16'hFF00;
      5, 6:    return 16'($urandom_range(0, 1023) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                           input logic [ROW_WIDTH-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    reg_writes++;
  endtask

  // Sender holds off until the block owes nothing, then lets culled items
  // still in the pipe run out.
  task automatic wait_pipe_empty();
    while (tri_pending_q.size() != 0 || start || proj_expect_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic queue_random(input int n);
    repeat (n)
      queue_triangle(pick_coord(), pick_coord(), pick_coord(),
                     pick_coord(), pick_coord(), pick_coord(),
                     pick_coord(), pick_coord(), pick_coord(),
                     3'($urandom_range(0, 7)), $urandom);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int idle_sets[3];
    int seg;
    idle_sets = '{22, 63, 0};

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset rows: identity x/y, depth row +z only. Only -Z and the
    // no-direction codes pass; the zero x and y coefficients cull both signs.
    send_idle_pct = 0;
    queue_triangle('0, '0, '0, '0, '0, '0, '0, '0, '0, FACE_NEG_Z, 32'h0);
    queue_triangle(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                   16'h0001, 16'hFFFF, 16'h0000, FACE_NEG_Z, 32'hFFFF_FFFF);
    for (int d = 0; d < 8; d++)
      queue_triangle(pick_coord(), pick_coord(), pick_coord(),
                     pick_coord(), pick_coord(), pick_coord(),
                     pick_coord(), pick_coord(), pick_coord(), 3'(d), $urandom);
    wait_pipe_empty();

    // Extreme rows: x and y saturate high for one vertex and low for another;
    // mixed depth signs keep +X, -Y and +Z.
    write_reg(CFG_X_ROW, {4{16'h7FFF}});
    write_reg(CFG_Y_ROW, {4{16'h8000}});
    write_reg(CFG_Z_ROW, 64'({16'h8000, 16'h7FFF, 16'h8000}));
    for (int d = 0; d < 6; d++)
      queue_triangle(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000,
                     16'h7FFF, 16'h8000, 16'h0000, 3'(d), $urandom);
    wait_pipe_empty();

    // Half-step coefficients put every product on a rounding tie (ties go up).
    // Zero depth row culls every axis direction. The unmapped write must not
    // touch any row.
    write_reg(CFG_X_ROW, 64'h0000_0000_0000_0080);
    write_reg(CFG_Y_ROW, 64'h0000_0000_0000_FF80);
    write_reg(CFG_Z_ROW, '0);
    write_reg(CFG_UNMAPPED, {ROW_WIDTH{1'b1}});
    queue_triangle(16'hFFFD, '0, '0, 16'hFFFF, '0, '0, 16'h0001, '0, '0,
                   FACE_NONE, 32'h1234_5678);
    queue_triangle(16'h0003, '0, '0, 16'h0005, '0, '0, 16'hFFFB, '0, '0,
                   3'd7, 32'h8765_4321);
    queue_triangle(16'h0003, '0, '0, '0, '0, '0, '0, '0, '0, FACE_POS_X, 32'h0);
    queue_triangle(16'h0003, '0, '0, '0, '0, '0, '0, '0, '0, FACE_NEG_X, 32'h0);
    wait_pipe_empty();

    // Random part: three sender idle settings, several register sets each,
    // with a full drain in the middle of every segment.
    seg = 0;
    foreach (idle_sets[i]) begin
      for (int s = 0; s < SEGS_PER_RUN; s++) begin
        send_idle_pct = 0;
        if (seg == 4) begin
          write_reg(CFG_X_ROW, {ROW_WIDTH{1'b1}});
          write_reg(CFG_Y_ROW, '0);
          write_reg(CFG_Z_ROW, {ROW_WIDTH{1'b1}});
        end else begin
          write_reg(CFG_X_ROW, {pick_coord(), pick_coef(), pick_coef(), pick_coef()});
          write_reg(CFG_Y_ROW, {pick_coord(), pick_coef(), pick_coef(), pick_coef()});
          write_reg(CFG_Z_ROW, {16'($urandom), pick_coef(), pick_coef(), pick_coef()});
        end
        send_idle_pct = idle_sets[i];
        queue_random(SEG_ITEMS);
        wait_pipe_empty();
        queue_random(SEG_ITEMS);
        wait_pipe_empty();
        seg++;
      end
    end

    if (proj_expect_q.size() != 0) begin
      mismatches++;
      $display("%0t: missing results: expected %0d more, actual 0",
               $time, proj_expect_q.size());
    end

    $display("Sent %0d triangles (%0d kept, %0d culled) across %0d register writes.",
             tris_sent, tris_kept, tris_culled, reg_writes);
    $display("Checked %0d projected results under three sender idle rates.",
             results_seen);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #5000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/core/vtfc_pkg.sv
rtl/core/vtfc_proj.sv
rtl/core/vertex_transform_face_cull.sv
tb/vertex_transform_face_cull_tb.sv
